// ===== design/skv_pkg.sv =====
`timescale 1ns / 1ps
// Package for the sorted key/value table: sizes, codes and shared types.
package skv_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DUP  = 2'd1,
        STAT_MISS = 2'd2,
        STAT_FULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_UPD
    } t_state;

    // Compare flags one cell hands back to the controller.
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage

// ===== design/skv_if.sv =====
`timescale 1ns / 1ps
// Handshake interfaces for the command and response channels.
interface skv_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   cmd;
    logic [skv_pkg::KEY_W-1:0]    key;
    logic [skv_pkg::VAL_W-1:0]    value;

    modport source (output valid, output cmd, output key, output value, input ready);
    modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface skv_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [skv_pkg::VAL_W-1:0]    value_out;
    logic [6:0]                   entry_count;

    modport source (output valid, output status, output value_out, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input value_out, input entry_count,
                    output ready);
endinterface

// ===== design/skv_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted table: holds an entry, compares it and shifts it.
module skv_cell (
    input  logic                       i_clk,
    input  logic                       i_valid,
    input  logic                       i_cap,
    input  logic [skv_pkg::KEY_W-1:0]  i_cmp_key,
    input  skv_pkg::t_cell_op          i_op,
    input  logic                       i_prev_lt,
    input  logic [skv_pkg::KEY_W-1:0]  i_new_key,
    input  logic [skv_pkg::VAL_W-1:0]  i_new_val,
    input  logic [skv_pkg::KEY_W-1:0]  i_left_key,
    input  logic [skv_pkg::VAL_W-1:0]  i_left_val,
    input  logic [skv_pkg::KEY_W-1:0]  i_right_key,
    input  logic [skv_pkg::VAL_W-1:0]  i_right_val,
    output logic [skv_pkg::KEY_W-1:0]  o_key,
    output logic [skv_pkg::VAL_W-1:0]  o_val,
    output skv_pkg::t_cell_flags       o_flags,
    output logic [skv_pkg::VAL_W-1:0]  o_hit_val
);

    logic [skv_pkg::KEY_W-1:0] r_key;
    logic [skv_pkg::VAL_W-1:0] r_val;
    logic [skv_pkg::KEY_W-1:0] n_key;
    logic [skv_pkg::VAL_W-1:0] n_val;
    skv_pkg::t_cell_flags      r_flags;

    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_flags.lt <= i_valid && (r_key < i_cmp_key);
            r_flags.eq <= i_valid && (r_key == i_cmp_key);
        end
        r_key <= n_key;
        r_val <= n_val;
    end

    // On insert, cells below the insertion point keep their entry; the first
    // cell at or above takes the new entry, the rest their left neighbour's.
    always_comb begin
        n_key = r_key;
        n_val = r_val;
        case (i_op)
            skv_pkg::CELL_INS: begin
                if (!r_flags.lt) begin
                    if (i_prev_lt) begin
                        n_key = i_new_key;
                        n_val = i_new_val;
                    end else begin
                        n_key = i_left_key;
                        n_val = i_left_val;
                    end
                end
            end
            skv_pkg::CELL_DEL: begin
                if (!r_flags.lt) begin
                    n_key = i_right_key;
                    n_val = i_right_val;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key     = r_key;
    assign o_val     = r_val;
    assign o_flags   = r_flags;
    assign o_hit_val = r_flags.eq ? r_val : '0;

endmodule

// ===== design/sorted_key_value_table.sv =====
`timescale 1ns / 1ps
// Top level of the sorted key/value table: command control and cell row.
//
// Commands arrive on i_cmd (add, get, remove) and each gives exactly one
// response beat on o_rsp with a status, the value found or removed, and the
// number of entries held afterwards.
// Entries sit in a row of CAPACITY cells kept in ascending key order. When a
// command beat is taken every cell compares its key with the new key in the
// same cycle; in the update that follows, once the output register is free,
// each cell keeps its entry, takes a neighbour's or takes the new one, so an
// insert or delete moves the whole row by one slot at once.
// A beat is taken only in the idle state, so a new beat waits until the
// last one has made its update; the response is registered and is valid from
// the cycle after that update, as the cell row compares first, then shifts.
// If the receiver holds o_rsp.ready low, the finished response waits in the
// output register; the next command can still be taken, and its update waits
// until the output register frees, which also holds i_cmd.ready low.
// Reset empties the table (count to zero) and drops any pending response;
// no clearing pass is needed, as slots beyond the count are never read.
module sorted_key_value_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    skv_cmd_if.sink       i_cmd,
    skv_rsp_if.source     o_rsp
);

    localparam int N = skv_pkg::CAPACITY;

    skv_pkg::t_state             r_state, n_state;
    logic [skv_pkg::CNT_W-1:0]   r_count, n_count;
    logic [1:0]                  r_cmd;
    logic [skv_pkg::KEY_W-1:0]   r_key;
    logic [skv_pkg::VAL_W-1:0]   r_value;
    logic                        r_o_valid, n_o_valid;
    logic [1:0]                  r_o_status, n_o_status;
    logic [skv_pkg::VAL_W-1:0]   r_o_value, n_o_value;

    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_update;
    logic                        w_hit;
    logic                        w_full;
    logic [skv_pkg::VAL_W-1:0]   w_hit_val;
    skv_pkg::t_cell_op           w_op;

    logic [skv_pkg::KEY_W-1:0]   w_key   [N];
    logic [skv_pkg::VAL_W-1:0]   w_val   [N];
    logic [skv_pkg::VAL_W-1:0]   w_hv    [N];
    skv_pkg::t_cell_flags        w_flags [N];
    logic [N-1:0]                w_lt;
    logic [N-1:0]                w_eq;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_free = !r_o_valid || o_rsp.ready;
    assign w_update   = (r_state == skv_pkg::ST_UPD) && w_out_free;
    assign i_cmd.ready = (r_state == skv_pkg::ST_IDLE);

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic                      w_prev_lt;
            logic [skv_pkg::KEY_W-1:0] w_lk, w_rk;
            logic [skv_pkg::VAL_W-1:0] w_lv, w_rv;

            if (g == 0) begin : g_first
                assign w_prev_lt = 1'b1;
                assign w_lk      = r_key;
                assign w_lv      = r_value;
            end else begin : g_mid
                assign w_prev_lt = w_lt[g-1];
                assign w_lk      = w_key[g-1];
                assign w_lv      = w_val[g-1];
            end
            if (g == N - 1) begin : g_last
                assign w_rk = r_key;
                assign w_rv = r_value;
            end else begin : g_body
                assign w_rk = w_key[g+1];
                assign w_rv = w_val[g+1];
            end

            skv_cell u_cell (
                .i_clk       (i_clk),
                .i_valid     (skv_pkg::CNT_W'(g) < r_count),
                .i_cap       (w_accept),
                .i_cmp_key   (i_cmd.key),
                .i_op        (w_op),
                .i_prev_lt   (w_prev_lt),
                .i_new_key   (r_key),
                .i_new_val   (r_value),
                .i_left_key  (w_lk),
                .i_left_val  (w_lv),
                .i_right_key (w_rk),
                .i_right_val (w_rv),
                .o_key       (w_key[g]),
                .o_val       (w_val[g]),
                .o_flags     (w_flags[g]),
                .o_hit_val   (w_hv[g])
            );

            assign w_lt[g] = w_flags[g].lt;
            assign w_eq[g] = w_flags[g].eq;
        end
    endgenerate

    // At most one cell matches, so an OR over the masked values selects it.
    always_comb begin
        w_hit_val = '0;
        for (int i = 0; i < N; i++) begin
            w_hit_val = w_hit_val | w_hv[i];
        end
    end

    assign w_hit  = |w_eq;
    assign w_full = (r_count == skv_pkg::CNT_W'(N));

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_value  = r_o_value;
        w_op       = skv_pkg::CELL_HOLD;
        unique case (r_state)
            skv_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = skv_pkg::ST_UPD;
                end
            end
            skv_pkg::ST_UPD: begin
                if (w_out_free) begin
                    n_state    = skv_pkg::ST_IDLE;
                    n_o_valid  = 1'b1;
                    n_o_status = skv_pkg::STAT_OK;
                    n_o_value  = '0;
                    case (r_cmd)
                        skv_pkg::CMD_ADD: begin
                            if (w_hit) begin
                                n_o_status = skv_pkg::STAT_DUP;
                            end else if (w_full) begin
                                n_o_status = skv_pkg::STAT_FULL;
                            end else begin
                                w_op    = skv_pkg::CELL_INS;
                                n_count = r_count + skv_pkg::CNT_W'(1);
                            end
                        end
                        skv_pkg::CMD_GET, skv_pkg::CMD_REMOVE: begin
                            if (!w_hit) begin
                                n_o_status = skv_pkg::STAT_MISS;
                            end else begin
                                n_o_value = w_hit_val;
                                if (r_cmd == skv_pkg::CMD_REMOVE) begin
                                    w_op    = skv_pkg::CELL_DEL;
                                    n_count = r_count - skv_pkg::CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = skv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= skv_pkg::ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_cmd.cmd;
            r_key   <= i_cmd.key;
            r_value <= i_cmd.value;
        end
        r_o_status <= n_o_status;
        r_o_value  <= n_o_value;
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.value_out   = r_o_value;
    assign o_rsp.entry_count = 7'(r_count);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= skv_pkg::CNT_W'(N))
        else $error("entry count beyond capacity");

    a_eq_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skv_pkg::ST_UPD) |-> $onehot0(w_eq))
        else $error("more than one cell matched the key");

    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == skv_pkg::ST_UPD))
        else $error("accepted beat did not start an update");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_update |=> $stable(r_count))
        else $error("entry count changed outside an update");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sorted key/value table with a scoreboard and random traffic.
module tb_top;

    localparam logic [1:0]       CMD_UNUSED   = 2'd3;
    localparam int unsigned      RANDOM_ITEMS = 1100;
    localparam int unsigned      CYCLE_LIMIT  = 300000;
    localparam int unsigned      SETTLE_CYCLES = 10;
    localparam int               KW           = skv_pkg::KEY_W;
    localparam int               VW           = skv_pkg::VAL_W;
    localparam int unsigned      CAP          = skv_pkg::CAPACITY;
    localparam logic [KW-1:0]    KEY_MAX      = '1;
    localparam logic [KW-1:0]    KEY_TOP_BIT  = {1'b1, {(KW-1){1'b0}}};
    localparam logic [VW-1:0]    VAL_MAX      = '1;
    localparam logic [VW-1:0]    VAL_TOP_BIT  = {1'b1, {(VW-1){1'b0}}};
    localparam int               PH_FILL      = 0;
    localparam int               PH_MIX       = 1;
    localparam int               PH_DRAIN     = 2;

    typedef struct {
        logic [1:0]    status;
        logic [VW-1:0] value_out;
        logic [6:0]    entry_count;
    } t_rsp_beat;

    // Mirrors the sorted table and queues the response each command should give.
    class kv_table_scoreboard;
        logic [KW-1:0] key_slots [CAP];
        logic [VW-1:0] val_slots [CAP];
        int unsigned   held;
        t_rsp_beat     expected_rsps [$];
        int unsigned   mismatches;

        function int unsigned find_slot(logic [KW-1:0] k, output bit hit);
            int unsigned i;
            i = 0;
            while (i < held && key_slots[i] < k)
                i++;
            hit = (i < held) && (key_slots[i] == k);
            return i;
        endfunction

        function void note_command(logic [1:0] op, logic [KW-1:0] k,
                                   logic [VW-1:0] v);
            t_rsp_beat   r;
            bit          hit;
            int unsigned pos;
            int unsigned j;
            r.status    = skv_pkg::STAT_OK;
            r.value_out = '0;
            if (op == skv_pkg::CMD_ADD) begin
                pos = find_slot(k, hit);
                // A duplicate key is reported even when the table is full.
                if (hit) begin
                    r.status = skv_pkg::STAT_DUP;
                end else if (held >= CAP) begin
                    r.status = skv_pkg::STAT_FULL;
                end else begin
                    for (j = held; j > pos; j--) begin
                        key_slots[j] = key_slots[j-1];
                        val_slots[j] = val_slots[j-1];
                    end
                    key_slots[pos] = k;
                    val_slots[pos] = v;
                    held++;
                end
            end else if (op == skv_pkg::CMD_GET || op == skv_pkg::CMD_REMOVE) begin
                pos = find_slot(k, hit);
                if (!hit) begin
                    r.status = skv_pkg::STAT_MISS;
                end else begin
                    r.value_out = val_slots[pos];
                    if (op == skv_pkg::CMD_REMOVE) begin
                        for (j = pos; j + 1 < held; j++) begin
                            key_slots[j] = key_slots[j+1];
                            val_slots[j] = val_slots[j+1];
                        end
                        held--;
                    end
                end
            end
            r.entry_count = held[6:0];
            expected_rsps.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_response(logic [1:0] st, logic [VW-1:0] vo, logic [6:0] cnt);
            t_rsp_beat e;
            if (expected_rsps.size() == 0) begin
                report_mismatch($sformatf("unexpected response status %0d value %h count %0d",
                                          st, vo, cnt));
                return;
            end
            e = expected_rsps.pop_front();
            if (st !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
            if (vo !== e.value_out)
                report_mismatch($sformatf("value %h, expected %h", vo, e.value_out));
            if (cnt !== e.entry_count)
                report_mismatch($sformatf("entry count %0d, expected %0d",
                                          cnt, e.entry_count));
        endtask

        function int unsigned pending();
            return expected_rsps.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    skv_cmd_if cmd_bus ();
    skv_rsp_if rsp_bus ();

    sorted_key_value_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    kv_table_scoreboard sb;
    int unsigned        items_sent;
    int unsigned        cycle_count;
    int unsigned        rx_hold;
    int unsigned        rx_beats;
    bit                 tx_calm;
    bit                 rx_calm;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: stalls for a drawn number of cycles after each beat, with calm stretches.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            sb.check_response(rsp_bus.status, rsp_bus.value_out, rsp_bus.entry_count);
            rx_beats++;
            if (rx_beats % 50 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            rx_hold = rx_calm ? 0 : $urandom_range(0, 7);
        end
    end

    task automatic send_command(logic [1:0] op, logic [KW-1:0] k, logic [VW-1:0] v);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge i_clk);
            cmd_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_bus.valid <= 1'b1;
        cmd_bus.cmd   <= op;
        cmd_bus.key   <= k;
        cmd_bus.value <= v;
        do
            @(posedge i_clk);
        while (!cmd_bus.ready);
        sb.note_command(op, k, v);
        items_sent++;
    endtask

    task automatic wait_all_answered();
        @(negedge i_clk);
        cmd_bus.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // String keys packed big-endian and zero padded, so their order is string order.
    function automatic logic [KW-1:0] word_key();
        logic [KW-1:0] w;
        int unsigned   n;
        int unsigned   i;
        w = '0;
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++)
            w[KW-1-8*i -: 8] = 8'h61 + 8'($urandom_range(0, 25));
        return w;
    endfunction

    function automatic logic [KW-1:0] fresh_key();
        case ($urandom_range(0, 3))
            0:       return {$urandom(), $urandom()};
            1:       return KW'($urandom_range(0, 63));
            2:       return word_key();
            default: return KEY_MAX - KW'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic logic [KW-1:0] pick_key(int unsigned hit_pct);
        if (sb.held > 0 && $urandom_range(0, 99) < hit_pct)
            return sb.key_slots[$urandom_range(0, sb.held - 1)];
        return fresh_key();
    endfunction

    task automatic run_phase(int kind);
        int unsigned extra;
        int unsigned len;
        int unsigned steps;
        int unsigned r;
        tx_calm = ($urandom_range(0, 3) == 0);
        extra   = $urandom_range(5, 15);
        len     = $urandom_range(40, 100);
        steps   = 0;
        while (steps < 400) begin
            if ((kind == PH_FILL && sb.held == CAP) ||
                (kind == PH_DRAIN && sb.held == 0)) begin
                if (extra == 0)
                    break;
                extra = extra - 1;
            end
            if (kind == PH_MIX && steps >= len)
                break;
            r = $urandom_range(0, 99);
            if (kind == PH_FILL) begin
                if (r < 80)
                    send_command(skv_pkg::CMD_ADD, pick_key(sb.held == CAP ? 50 : 10),
                                 $urandom());
                else if (r < 90)
                    send_command(skv_pkg::CMD_GET, pick_key(70), $urandom());
                else if (r < 97)
                    send_command(skv_pkg::CMD_REMOVE, pick_key(70), $urandom());
                else
                    send_command(CMD_UNUSED, pick_key(50), $urandom());
            end else if (kind == PH_DRAIN) begin
                if (r < 75)
                    send_command(skv_pkg::CMD_REMOVE, pick_key(85), $urandom());
                else if (r < 85)
                    send_command(skv_pkg::CMD_ADD, pick_key(30), $urandom());
                else if (r < 97)
                    send_command(skv_pkg::CMD_GET, pick_key(70), $urandom());
                else
                    send_command(CMD_UNUSED, pick_key(50), $urandom());
            end else begin
                if (r < 35)
                    send_command(skv_pkg::CMD_ADD, pick_key(30), $urandom());
                else if (r < 65)
                    send_command(skv_pkg::CMD_GET, pick_key(60), $urandom());
                else if (r < 95)
                    send_command(skv_pkg::CMD_REMOVE, pick_key(60), $urandom());
                else
                    send_command(CMD_UNUSED, pick_key(50), $urandom());
            end
            steps++;
        end
    endtask

    initial begin
        int unsigned phase_no;
        int unsigned start_items;
        int          kind;
        sb            = new;
        i_rst_n       = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.cmd   = skv_pkg::CMD_ADD;
        cmd_bus.key   = '0;
        cmd_bus.value = '0;
        rsp_bus.ready = 1'b0;
        rx_hold       = 0;
        rx_calm       = 1'b0;
        tx_calm       = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, key and value extremes, duplicates, misses, unused code.
        send_command(skv_pkg::CMD_GET,    '0,          '0);
        send_command(skv_pkg::CMD_REMOVE, KEY_MAX,     VAL_MAX);
        send_command(skv_pkg::CMD_ADD,    '0,          VAL_MAX);
        send_command(skv_pkg::CMD_ADD,    KEY_MAX,     '0);
        send_command(skv_pkg::CMD_ADD,    '0,          32'h0000_1234);
        send_command(skv_pkg::CMD_ADD,    KEY_TOP_BIT, VAL_TOP_BIT);
        send_command(skv_pkg::CMD_ADD,    64'd1,       32'd1);
        send_command(skv_pkg::CMD_GET,    KEY_MAX,     VAL_MAX);
        send_command(skv_pkg::CMD_GET,    '0,          '0);
        send_command(skv_pkg::CMD_GET,    ~KEY_TOP_BIT, '0);
        send_command(CMD_UNUSED,          '0,          VAL_MAX);
        send_command(skv_pkg::CMD_REMOVE, 64'd1,       '0);
        send_command(skv_pkg::CMD_REMOVE, 64'd1,       '0);
        send_command(skv_pkg::CMD_GET,    KEY_TOP_BIT, '0);
        send_command(skv_pkg::CMD_ADD,    64'h6170_706C_6500_0000, 32'hA5A5_5A5A);
        send_command(skv_pkg::CMD_ADD,    64'h6170_706C_6573_0000, 32'h5A5A_A5A5);
        send_command(skv_pkg::CMD_ADD,    64'h6170_706C_6500_0000, 32'hFFFF_0000);
        send_command(skv_pkg::CMD_GET,    64'h6170_706C_6500_0000, '0);
        send_command(skv_pkg::CMD_REMOVE, 64'h6170_706C_6573_0000, '0);
        send_command(skv_pkg::CMD_REMOVE, '0,          '0);
        send_command(skv_pkg::CMD_REMOVE, KEY_MAX,     '0);
        send_command(skv_pkg::CMD_REMOVE, KEY_TOP_BIT, '0);
        send_command(skv_pkg::CMD_REMOVE, 64'h6170_706C_6500_0000, '0);
        send_command(skv_pkg::CMD_GET,    '0,          '0);

        start_items = items_sent;
        phase_no    = 0;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            case (phase_no % 4)
                0:       kind = PH_FILL;
                2:       kind = PH_DRAIN;
                default: kind = PH_MIX;
            endcase
            run_phase(kind);
            // Let the pipeline run dry now and then, always after the first fill.
            if (phase_no == 0 || $urandom_range(0, 2) == 0)
                wait_all_answered();
            phase_no++;
        end

        wait_all_answered();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sorted_key_value_table.f =====
design/skv_pkg.sv
design/skv_if.sv
design/skv_cell.sv
design/sorted_key_value_table.sv
verif/tb_top.sv
